// ===== src/wsec_pkg.sv =====
// ----------------------------------------------------------------------------
// wsec_pkg
// Shared constants and lane control type for the windowed spread block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsec_pkg;

  localparam int NUM_LANES    = 9;
  localparam int DEF_WINDOW   = 50;
  localparam int DEF_CHANNELS = 9;

  localparam int SAMPLE_W = 16;
  localparam int SPREAD_W = 24;
  localparam int ALPHA_W  = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  // root of a 64-bit radicand, two bits a cycle; 32-bit quotient, four bits a cycle
  localparam int SQRT_CYCLES = 16;
  localparam int DIV_CYCLES  = 8;

  typedef struct packed {
    logic accept;        // write sample, read oldest entry
    logic square;        // square new and oldest sample
    logic sums;          // update running sums
    logic subtract_old;  // window already full: drop oldest sample
    logic diff_mul;      // W*Q and S*S
    logic diff_sub;      // variance numerator, load root unit
    logic sqrt_step;
    logic div_step;
    logic ema_mul;
    logic ema_add;
  } wsec_ctrl_t;

endpackage

`default_nettype wire

// ===== src/wsec_lane.sv =====
// ----------------------------------------------------------------------------
// wsec_lane
// One channel: sample window, running sums, serial root and divide, smoothing.
// ----------------------------------------------------------------------------
`default_nettype none

module wsec_lane
  import wsec_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wsec_ctrl_t                 ctrl,
  input  wire logic [$clog2(WINDOW)-1:0]  addr,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [ALPHA_W-1:0]         alpha,
  output logic [SPREAD_W-1:0]             spread
);

  localparam int AW   = $clog2(WINDOW);
  localparam int DR_W = AW + 1;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic signed [SAMPLE_W-1:0] new_q, old_q;
  logic [31:0] sq_new, sq_old;
  logic signed [23:0] sum;
  logic [39:0] sq_sum;
  logic [47:0] wq, ss;
  logic signed [47:0] sum_sq;

  logic [63:0] rad_x, rad_x_next;
  logic [34:0] rad_r, rad_r_next;
  logic [31:0] root, root_next;

  logic [DR_W-1:0] div_r, div_r_next;
  logic [31:0] div_q, div_q_next;

  logic [47:0] pa;
  logic [48:0] pb;
  logic [49:0] ema_sum;
  logic [31:0] sm;
  logic [32:0] rounded;

  // oldest entry is read before it is overwritten
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      old_q     <= mem[addr];
      mem[addr] <= sample;
      new_q     <= sample;
    end
  end

  assign sum_sq = sum * sum;

  always_comb begin
    logic [34:0] r, t;
    logic [31:0] q;
    logic [63:0] x;
    r = rad_r;
    q = root;
    x = rad_x;
    for (int i = 0; i < 2; i++) begin
      r = {r[32:0], x[63:62]};
      x = {x[61:0], 2'b00};
      t = {1'b0, q, 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
    end
    rad_r_next = r;
    root_next  = q;
    rad_x_next = x;
  end

  always_comb begin
    logic [DR_W-1:0] r;
    logic [31:0] q;
    r = div_r;
    q = div_q;
    for (int i = 0; i < 4; i++) begin
      r = {r[DR_W-2:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= DR_W'(WINDOW)) begin
        r    = r - DR_W'(WINDOW);
        q[0] = 1'b1;
      end
    end
    div_r_next = r;
    div_q_next = q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.square) begin
      sq_new <= 32'(new_q * new_q);
      sq_old <= 32'(old_q * old_q);
    end
    if (ctrl.diff_mul) begin
      wq <= 48'(sq_sum) * 48'(WINDOW);
      ss <= 48'(sum_sq);
    end
    if (ctrl.diff_sub) begin
      rad_x <= {wq - ss, 16'h0000};
      rad_r <= '0;
      root  <= '0;
    end else if (ctrl.sqrt_step) begin
      rad_x <= rad_x_next;
      rad_r <= rad_r_next;
      root  <= root_next;
    end
    if (ctrl.sqrt_step) begin
      div_r <= '0;
      div_q <= root_next;
    end else if (ctrl.div_step) begin
      div_r <= div_r_next;
      div_q <= div_q_next;
    end
    if (ctrl.ema_mul) begin
      pa <= 48'(alpha) * 48'({div_q[23:0], 8'h00});
      pb <= 49'(17'(17'h10000 - 17'(alpha))) * 49'(sm);
    end
  end

  assign ema_sum = 50'(pa) + 50'(pb) + 50'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      sq_sum <= '0;
      sm     <= '0;
    end else begin
      if (ctrl.sums) begin
        sum    <= sum + 24'(new_q) - (ctrl.subtract_old ? 24'(old_q) : 24'sd0);
        sq_sum <= sq_sum + 40'(sq_new) - (ctrl.subtract_old ? 40'(sq_old) : 40'd0);
      end
      if (ctrl.ema_add) sm <= ema_sum[47:16];
    end
  end

  assign rounded = 33'(sm) + 33'd128;
  assign spread  = rounded[31:8];

endmodule

`default_nettype wire

// ===== src/windowed_std_ema_nine_channel_top.sv =====
// ----------------------------------------------------------------------------
// windowed_std_ema_nine_channel_top
// Nine-channel moving-window standard deviation with exponential smoothing.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one sample per channel; output
// channel out_valid/out_ready carries the nine smoothed spreads (Q.8) and
// window_full. cfg_write_en/cfg_write_data set alpha (Q0.16) at once.
// One item at a time: an item that fills or follows a full window passes
// the square, sums, product and difference steps, the serial root (two bits
// a step), the divide by WINDOW (four bits a step) and the smoothing multiply
// and add before its result is registered. Before the window has filled, an
// item goes from the sums step to done, and the spreads keep their values.
// All lanes run in step under one sequencer.
// The result is held in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished item waits in the sequencer until
// the output register frees, and in_ready stays low meanwhile.
// Reset clears the sums, smoothed values, write position and the full flag
// and loads alpha with its default; the sample memory is not cleared, since
// an entry is only read back after it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_std_ema_nine_channel_top
  import wsec_pkg::*;
#(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write_en,
  input  wire logic [ALPHA_W-1:0]         cfg_write_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample_ax,
  input  wire logic signed [SAMPLE_W-1:0] sample_ay,
  input  wire logic signed [SAMPLE_W-1:0] sample_az,
  input  wire logic signed [SAMPLE_W-1:0] sample_gx,
  input  wire logic signed [SAMPLE_W-1:0] sample_gy,
  input  wire logic signed [SAMPLE_W-1:0] sample_gz,
  input  wire logic signed [SAMPLE_W-1:0] sample_yaw,
  input  wire logic signed [SAMPLE_W-1:0] sample_pitch,
  input  wire logic signed [SAMPLE_W-1:0] sample_roll,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [SPREAD_W-1:0]             spread_ax,
  output logic [SPREAD_W-1:0]             spread_ay,
  output logic [SPREAD_W-1:0]             spread_az,
  output logic [SPREAD_W-1:0]             spread_gx,
  output logic [SPREAD_W-1:0]             spread_gy,
  output logic [SPREAD_W-1:0]             spread_gz,
  output logic [SPREAD_W-1:0]             spread_yaw,
  output logic [SPREAD_W-1:0]             spread_pitch,
  output logic [SPREAD_W-1:0]             spread_roll,
  output logic                            window_full
);

  localparam int AW = $clog2(WINDOW);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SUMS, S_DMUL, S_DSUB, S_SQRT, S_DIV,
    S_EMA_MUL, S_EMA_ADD, S_DONE
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic [AW-1:0] pos;
  logic filled;
  logic [ALPHA_W-1:0] alpha;
  wsec_ctrl_t ctrl;

  logic signed [SAMPLE_W-1:0] samples [NUM_LANES];
  logic [SPREAD_W-1:0] spreads [NUM_LANES];
  logic [SPREAD_W-1:0] out_spread [NUM_LANES];

  assign samples[0] = sample_ax;
  assign samples[1] = sample_ay;
  assign samples[2] = sample_az;
  assign samples[3] = sample_gx;
  assign samples[4] = sample_gy;
  assign samples[5] = sample_gz;
  assign samples[6] = sample_yaw;
  assign samples[7] = sample_pitch;
  assign samples[8] = sample_roll;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctrl              = '0;
    ctrl.accept       = in_valid && in_ready;
    ctrl.square       = (state == S_SQUARE);
    ctrl.sums         = (state == S_SUMS);
    ctrl.subtract_old = filled;
    ctrl.diff_mul     = (state == S_DMUL);
    ctrl.diff_sub     = (state == S_DSUB);
    ctrl.sqrt_step    = (state == S_SQRT);
    ctrl.div_step     = (state == S_DIV);
    ctrl.ema_mul      = (state == S_EMA_MUL);
    ctrl.ema_add      = (state == S_EMA_ADD);
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      wsec_lane #(.WINDOW(WINDOW)) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .addr   (pos),
        .sample (samples[g]),
        .alpha  (alpha),
        .spread (spreads[g])
      );
    end else begin : g_off
      assign spreads[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_write_en) begin
      alpha <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pos         <= '0;
      filled      <= 1'b0;
      out_valid   <= 1'b0;
      window_full <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SQUARE;
        end
        S_SQUARE: state <= S_SUMS;
        S_SUMS: begin
          if (pos == AW'(WINDOW - 1)) begin
            pos    <= '0;
            filled <= 1'b1;
            state  <= S_DMUL;
          end else begin
            pos   <= pos + 1'b1;
            state <= filled ? S_DMUL : S_DONE;
          end
        end
        S_DMUL: state <= S_DSUB;
        S_DSUB: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt == 4'(SQRT_CYCLES - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt == 4'(DIV_CYCLES - 1)) begin
            cnt   <= '0;
            state <= S_EMA_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMA_MUL: state <= S_EMA_ADD;
        S_EMA_ADD: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            window_full <= filled;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      for (int i = 0; i < NUM_LANES; i++) out_spread[i] <= spreads[i];
    end
  end

  assign spread_ax    = out_spread[0];
  assign spread_ay    = out_spread[1];
  assign spread_az    = out_spread[2];
  assign spread_gx    = out_spread[3];
  assign spread_gy    = out_spread[4];
  assign spread_gz    = out_spread[5];
  assign spread_yaw   = out_spread[6];
  assign spread_pitch = out_spread[7];
  assign spread_roll  = out_spread[8];

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < WINDOW)
    else $error("write position beyond window");

  a_filled_sticks: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled)
    else $error("full flag dropped");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_SQUARE)
    else $error("accepted item not started");

  a_full_flag_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_full) |-> filled)
    else $error("window_full shown before window filled");

endmodule

`default_nettype wire
